// File: hw/rtl/xesp_pkg.sv
// Shared types and constants of the XMI event stream parser.
// Used by all parser modules; depends on nothing.
`default_nettype none

package xesp_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_CHANNEL   = 2'd0;
   localparam logic [1:0] KIND_META_HEAD = 2'd1;
   localparam logic [1:0] KIND_META_DATA = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   // High nibbles of the status bytes.
   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_AFTER    = 4'hA;
   localparam logic [3:0] NIB_CTRL     = 4'hB;
   localparam logic [3:0] NIB_PROG     = 4'hC;
   localparam logic [3:0] NIB_PITCH    = 4'hE;
   localparam logic [3:0] NIB_META     = 4'hF;

   // Meta type that ends a track.
   localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

   // Depth of the queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One parsed result on its way to the output stage. The stamp is formed
   // later as base_time + addend, where addend is the note duration for a
   // derived note-off and zero otherwise.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] base_time;
      logic [31:0] addend;
      logic [7:0]  status_byte;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [1:0]  data_count;
      logic        track_end;
   } xesp_item_type;

endpackage

`default_nettype wire

// File: hw/rtl/xesp_req_if.sv
// Input channel of the parser: one raw byte of the event chunk per transaction.
// Stand-alone interface, no dependencies.
`default_nettype none

interface xesp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/xesp_rsp_if.sv
// Parser result channel: one event, meta header, meta byte or error per transaction.
// Stand-alone interface, no dependencies.
`default_nettype none

interface xesp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] stamp;
   logic [7:0]  status_byte;
   logic [7:0]  first_data;
   logic [7:0]  second_data;
   logic [1:0]  data_count;
   logic        track_end;

   modport source (output valid, output kind, output stamp, output status_byte,
                   output first_data, output second_data, output data_count,
                   output track_end, input ready);
   modport sink   (input valid, input kind, input stamp, input status_byte,
                   input first_data, input second_data, input data_count,
                   input track_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/xesp_front.sv
// Front end of the parser: takes bytes, tracks the parse phase and running
// time, and pushes at most one result item per byte. Depends on xesp_pkg.
`default_nettype none

module xesp_front import xesp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   xesp_req_if.sink           req_bus,
   input  wire logic          queue_full,
   output logic               push,
   output xesp_item_type      push_item
);

   // Parse phases.
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_D1    = 3'd1;
   localparam logic [2:0] PH_D2    = 3'd2;
   localparam logic [2:0] PH_PROG  = 3'd3;
   localparam logic [2:0] PH_DUR   = 3'd4;
   localparam logic [2:0] PH_MTYPE = 3'd5;
   localparam logic [2:0] PH_MLEN  = 3'd6;
   localparam logic [2:0] PH_MDATA = 3'd7;

   // Run state.
   localparam logic [1:0] RUN_ACTIVE   = 2'd0;
   localparam logic [1:0] RUN_FINISHED = 2'd1;
   localparam logic [1:0] RUN_FAILED   = 2'd2;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  run_ff, run_in;
   logic [31:0] time_ff, time_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [31:0] dur_ff, dur_in;
   logic [7:0]  remain_ff, remain_in;
   logic        accept;
   logic [7:0]  b;

   // A byte can always be taken while the queue has room for its result.
   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;
   assign b             = req_bus.stream_byte;

   // Parse one byte.
   always_comb begin
      phase_in  = phase_ff;
      run_in    = run_ff;
      time_in   = time_ff;
      status_in = status_ff;
      first_in  = first_ff;
      second_in = second_ff;
      dur_in    = dur_ff;
      remain_in = remain_ff;
      push      = 1'b0;
      push_item = '{kind: KIND_CHANNEL, base_time: time_ff, addend: 32'd0,
                    status_byte: status_ff, first_data: first_ff,
                    second_data: second_ff, data_count: 2'd2, track_end: 1'b0};

      if (accept && run_ff == RUN_ACTIVE) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!b[7]) begin
                  time_in = time_ff + {24'd0, b};
               end else begin
                  status_in = b;
                  unique case (b[7:4]) inside
                     NIB_NOTE_ON, NIB_AFTER, NIB_CTRL, NIB_PITCH: phase_in = PH_D1;
                     NIB_PROG: phase_in = PH_PROG;
                     NIB_META: phase_in = PH_MTYPE;
                     default: begin
                        // Note-off and channel pressure are not legal here.
                        run_in = RUN_FAILED;
                        push   = 1'b1;
                        push_item.kind        = KIND_ERROR;
                        push_item.status_byte = b;
                        push_item.first_data  = 8'd0;
                        push_item.second_data = 8'd0;
                        push_item.data_count  = 2'd0;
                     end
                  endcase
               end
            end
            PH_D1: begin
               first_in = b;
               phase_in = PH_D2;
            end
            PH_D2: begin
               second_in = b;
               if (status_ff[7:4] == NIB_NOTE_ON || status_ff[7:4] == NIB_AFTER) begin
                  dur_in   = 32'd0;
                  phase_in = PH_DUR;
               end else begin
                  phase_in = PH_IDLE;
               end
               push = 1'b1;
               push_item.second_data = b;
            end
            PH_PROG: begin
               first_in = b;
               phase_in = PH_IDLE;
               push     = 1'b1;
               push_item.first_data  = b;
               push_item.second_data = 8'd0;
               push_item.data_count  = 2'd1;
            end
            PH_DUR: begin
               // Variable-length duration, seven bits per byte.
               dur_in = {dur_ff[24:0], b[6:0]};
               if (!b[7]) begin
                  phase_in = PH_IDLE;
                  push     = 1'b1;
                  push_item.addend      = dur_in;
                  push_item.status_byte = {NIB_NOTE_OFF, status_ff[3:0]};
               end
            end
            PH_MTYPE: begin
               first_in = b;
               phase_in = PH_MLEN;
            end
            PH_MLEN: begin
               second_in = b;
               remain_in = b;
               push      = 1'b1;
               push_item.kind        = KIND_META_HEAD;
               push_item.second_data = b;
               if (b == 8'd0) begin
                  phase_in = PH_IDLE;
                  if (first_ff == META_END_OF_TRACK) begin
                     run_in = RUN_FINISHED;
                     push_item.track_end = 1'b1;
                  end
               end else begin
                  phase_in = PH_MDATA;
               end
            end
            PH_MDATA: begin
               remain_in = remain_ff - 8'd1;
               push      = 1'b1;
               push_item.kind        = KIND_META_DATA;
               push_item.first_data  = b;
               push_item.second_data = 8'd0;
               push_item.data_count  = 2'd1;
               if (remain_in == 8'd0) begin
                  phase_in = PH_IDLE;
                  if (first_ff == META_END_OF_TRACK) begin
                     run_in = RUN_FINISHED;
                     push_item.track_end = 1'b1;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         run_ff    <= RUN_ACTIVE;
         time_ff   <= 32'd0;
         status_ff <= 8'd0;
         first_ff  <= 8'd0;
         second_ff <= 8'd0;
         dur_ff    <= 32'd0;
         remain_ff <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         run_ff    <= run_in;
         time_ff   <= time_in;
         status_ff <= status_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         dur_ff    <= dur_in;
         remain_ff <= remain_in;
      end
   end

   // An error result halts the parser.
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      push && push_item.kind == KIND_ERROR |=> run_ff == RUN_FAILED)
      else $error("parser did not halt after an error result");

   // The end-of-track result finishes the track.
   a_end_finishes: assert property (@(posedge clock) disable iff (reset)
      push && push_item.track_end |=> run_ff == RUN_FINISHED)
      else $error("parser did not stop after end of track");

   // Nothing is produced once the track has ended or failed.
   a_quiet_when_stopped: assert property (@(posedge clock) disable iff (reset)
      run_ff != RUN_ACTIVE |-> !push)
      else $error("result produced after the parser stopped");

endmodule

`default_nettype wire

// File: hw/rtl/xesp_queue.sv
// Small register queue between the parser front end and the output stage.
// Depends on xesp_pkg for the item type and depth.
`default_nettype none

module xesp_queue import xesp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire xesp_item_type push_item,
   input  wire logic          pop,
   output xesp_item_type      head_item,
   output logic               full,
   output logic               empty
);

   xesp_item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

endmodule

`default_nettype wire

// File: hw/rtl/xesp_back.sv
// Output stage of the parser: pulls items from the queue, forms the final
// time stamp and holds the result until the sink takes it. Depends on xesp_pkg.
`default_nettype none

module xesp_back import xesp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire xesp_item_type head_item,
   input  wire logic          queue_empty,
   output logic               pop,
   xesp_rsp_if.source         rsp_bus
);

   logic        valid_ff;
   logic [1:0]  kind_ff;
   logic [31:0] stamp_ff;
   logic [7:0]  status_ff;
   logic [7:0]  first_ff;
   logic [7:0]  second_ff;
   logic [1:0]  count_ff;
   logic        end_ff;

   // Load a new item whenever the output register is free or being emptied.
   assign pop = !queue_empty && (!valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Result payload; a note-off gets its duration added here.
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= head_item.kind;
         stamp_ff  <= head_item.base_time + head_item.addend;
         status_ff <= head_item.status_byte;
         first_ff  <= head_item.first_data;
         second_ff <= head_item.second_data;
         count_ff  <= head_item.data_count;
         end_ff    <= head_item.track_end;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.kind        = kind_ff;
   assign rsp_bus.stamp       = stamp_ff;
   assign rsp_bus.status_byte = status_ff;
   assign rsp_bus.first_data  = first_ff;
   assign rsp_bus.second_data = second_ff;
   assign rsp_bus.data_count  = count_ff;
   assign rsp_bus.track_end   = end_ff;

endmodule

`default_nettype wire

// File: hw/rtl/xmi_event_stream_parser_unit.sv
// Top level of the XMI event stream parser.
// Depends on xesp_pkg, xesp_req_if, xesp_rsp_if, xesp_front, xesp_queue, xesp_back.
`default_nettype none

// The parser takes one byte of an XMI event chunk per clock cycle and emits
// decoded channel events, derived note-offs, meta headers and meta data bytes
// in stream order, at most one result per byte. The front end parses each byte
// combinationally, so the sustained rate is one byte per clock as long as
// results are taken; a result passes the queue and the output register before
// it appears. A four-entry queue sits between the parser and the output
// register, so the input stays ready while up to three results wait in it;
// only when that queue is full does the input stall. After an end-of-track
// event or an unknown status byte (0x8n or 0xDn, reported as an error
// result) every further byte is accepted and dropped until reset.
module xmi_event_stream_parser_unit import xesp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   xesp_req_if.sink    req_bus,
   xesp_rsp_if.source  rsp_bus
);

   logic          push;
   logic          pop;
   logic          queue_full;
   logic          queue_empty;
   xesp_item_type push_item;
   xesp_item_type head_item;

   xesp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   xesp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   xesp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_item   (head_item),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire
